// ----- design/acc_pkg.sv -----
package acc_pkg;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLK_EXT     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RC_PERIOD   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CPI         = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RES_BITS    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_JUST  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOW_PRESENT = 3'd5;

  // Control byte bit positions.
  localparam int BIT_ADON = 0;
  localparam int BIT_DONE = 1;
  localparam int BIT_GO   = 2;

  // Clock-select codes in control bits 7:6.
  localparam logic [1:0] CS_DIV2  = 2'd0;
  localparam logic [1:0] CS_DIV8  = 2'd1;
  localparam logic [1:0] CS_DIV32 = 2'd2;

  // Channel field width that drives the analog multiplexer.
  localparam int CHANNEL_SELECT_BITS = 3;
  localparam logic [2:0] CHAN_MASK = 3'((1 << CHANNEL_SELECT_BITS) - 1);

  // Widest conversion result and the reciprocal used for a divide by three.
  localparam int MAX_RES_BITS = 10;
  localparam logic [11:0] RECIP3 = 12'd2731;
  localparam int OUT_W = 32;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ACQ  = 2'd1,
    PH_CONV = 2'd2
  } phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;
    logic mul;
    logic load;
    logic pack;
  } acc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finish;
    logic div_busy;
  } acc_status_t;

  // Oscillator cycles per tick, saturated into 1..4.
  function automatic logic [2:0] eff_cpi(input logic [2:0] c);
    logic [2:0] r;
    r = c;
    if (c == 3'd0) r = 3'd1;
    if (c > 3'd4) r = 3'd4;
    return r;
  endfunction

  // Resolution, saturated into 8..10.
  function automatic logic [3:0] eff_bits(input logic [3:0] b);
    logic [3:0] r;
    r = b;
    if (b < 4'd8) r = 4'd8;
    if (b > 4'd10) r = 4'd10;
    return r;
  endfunction

  // Full-scale code for an effective resolution.
  function automatic logic [MAX_RES_BITS-1:0] scale_of(input logic [3:0] b);
    logic [MAX_RES_BITS-1:0] r;
    case (b)
      4'd8:    r = 10'd255;
      4'd9:    r = 10'd511;
      default: r = 10'd1023;
    endcase
    return r;
  endfunction

  // Conversion clock period in oscillator cycles for a clock-select code.
  function automatic logic [7:0] period_of(input logic [1:0] cs, input logic ext,
                                           input logic [7:0] rc);
    logic [7:0] r;
    unique case (cs)
      CS_DIV2:  r = ext ? 8'd4 : 8'd2;
      CS_DIV8:  r = ext ? 8'd16 : 8'd8;
      CS_DIV32: r = ext ? 8'd64 : 8'd32;
      default:  r = (rc < 8'd2) ? 8'd2 : rc;
    endcase
    return r;
  endfunction

  // Divide a tick count by an effective cpi of 1..4; three uses a reciprocal.
  function automatic logic [11:0] div_cpi(input logic [11:0] x, input logic [2:0] cpi);
    logic [23:0] p;
    logic [11:0] r;
    p = 24'(x) * 24'(RECIP3);
    case (cpi)
      3'd1:    r = x;
      3'd2:    r = x >> 1;
      3'd3:    r = {1'b0, p[23:13]};
      default: r = x >> 2;
    endcase
    return r;
  endfunction

endpackage

// ----- design/acc_div.sv -----
module acc_div #(
  parameter int DW = 28,
  parameter int VW = 17,
  parameter int QW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [QW-1:0] quotient
);

  localparam int SW = VW + QW - 1;
  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r;
  logic [SW-1:0] sh_r;
  logic [QW-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          ge;

  // Trial subtract of the shifted divisor, one quotient bit per cycle.
  assign ge = rem_r >= DW'(sh_r);
  assign busy = cnt_r != '0;
  assign quotient = q_r;

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= CW'(QW);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Remainder, shifted divisor and quotient.
  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= dividend;
      sh_r  <= SW'(divisor) << (QW - 1);
      q_r   <= '0;
    end else if (busy) begin
      if (ge) begin
        rem_r <= rem_r - DW'(sh_r);
      end
      sh_r <= sh_r >> 1;
      q_r  <= {q_r[QW-2:0], ge};
    end
  end

endmodule

// ----- design/acc_datapath.sv -----
module acc_datapath #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [acc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]                    cfg_wdata,
  input  logic                          item_op,
  input  logic [7:0]                    item_wval,
  input  logic [LEVEL_BITS-1:0]         item_vin,
  input  logic [LEVEL_BITS-1:0]         item_vhi,
  input  logic [LEVEL_BITS-1:0]         item_vlo,
  input  acc_pkg::acc_cmd_t             cmd,
  output acc_pkg::acc_status_t          status,
  output logic [7:0]                    control_value,
  output logic [7:0]                    result_high,
  output logic [7:0]                    result_low,
  output logic [2:0]                    selected_channel,
  output logic [1:0]                    phase,
  output logic                          done_interrupt
);
  import acc_pkg::*;

  localparam int QW = MAX_RES_BITS;
  localparam int PW = LEVEL_BITS + QW;
  localparam int DW = LEVEL_BITS + QW + 2;
  localparam int VW = LEVEL_BITS + 1;

  // Configuration registers.
  logic       cfg_ext_r;
  logic [7:0] cfg_rc_r;
  logic [2:0] cfg_cpi_r;
  logic [3:0] cfg_bits_r;
  logic       cfg_rj_r;
  logic       cfg_low_r;

  // Architectural state.
  logic [7:0]            ctrl_r, ctrl_nxt;
  phase_t                phase_r, phase_nxt;
  logic [11:0]           ticks_r, ticks_nxt;
  logic [7:0]            period_r, period_nxt;
  logic [LEVEL_BITS-1:0] vin_r, vhi_r, vlo_r;
  logic [7:0]            res0_r, res0_nxt, res1_r, res1_nxt;
  logic                  done_r, done_nxt;
  logic                  sample;

  // Conversion arithmetic.
  logic [PW-1:0]         prod_r;
  logic [LEVEL_BITS-1:0] den_r;
  logic                  zero_r, full_r;
  logic [QW-1:0]         quotient;
  logic [QW-1:0]         conv;
  logic [QW-1:0]         scale;
  logic [3:0]            bits_eff;
  logic                  div_busy;

  // Tick counts.
  logic [7:0]  period_sel;
  logic [11:0] tick_base, tick_load, ticks_dec;
  logic        finish;

  // Configuration write decode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ext_r  <= 1'b0;
      cfg_rc_r   <= 8'd6;
      cfg_cpi_r  <= 3'd4;
      cfg_bits_r <= 4'd8;
      cfg_rj_r   <= 1'b0;
      cfg_low_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CLK_EXT:     cfg_ext_r  <= cfg_wdata[0];
        CFG_RC_PERIOD:   cfg_rc_r   <= cfg_wdata;
        CFG_CPI:         cfg_cpi_r  <= cfg_wdata[2:0];
        CFG_RES_BITS:    cfg_bits_r <= cfg_wdata[3:0];
        CFG_RIGHT_JUST:  cfg_rj_r   <= cfg_wdata[0];
        CFG_LOW_PRESENT: cfg_low_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Phase length: twice the period on a start, resolution times period at sampling.
  assign bits_eff   = eff_bits(cfg_bits_r);
  assign scale      = scale_of(bits_eff);
  assign period_sel = period_of(item_wval[7:6], cfg_ext_r, cfg_rc_r);
  assign tick_base  = item_op ? {3'b000, period_sel, 1'b0} : 12'(bits_eff * period_r);
  assign tick_load  = div_cpi(tick_base, eff_cpi(cfg_cpi_r));
  assign ticks_dec  = ticks_r - 1'b1;

  // Final code: clamped ends or the rounded quotient.
  assign conv = zero_r ? '0 : (full_r ? scale : quotient);

  // Next state for a request and for the end of a conversion.
  always_comb begin
    ctrl_nxt   = ctrl_r;
    phase_nxt  = phase_r;
    ticks_nxt  = ticks_r;
    period_nxt = period_r;
    res0_nxt   = res0_r;
    res1_nxt   = res1_r;
    done_nxt   = done_r;
    sample     = 1'b0;
    finish     = 1'b0;
    if (item_op) begin
      if (item_wval[BIT_ADON]) begin
        if (item_wval[BIT_GO] && !ctrl_r[BIT_GO]) begin
          ticks_nxt = tick_load;
          phase_nxt = PH_ACQ;
        end
      end else begin
        phase_nxt = PH_IDLE;
      end
      ctrl_nxt   = item_wval;
      period_nxt = period_sel;
    end else if (phase_r != PH_IDLE) begin
      ticks_nxt = ticks_dec;
      if (ticks_dec == '0) begin
        if (phase_r == PH_ACQ) begin
          sample    = 1'b1;
          ticks_nxt = tick_load;
          phase_nxt = PH_CONV;
          finish    = tick_load == '0;
        end else begin
          finish = 1'b1;
        end
      end
    end
    if (cmd.step) begin
      done_nxt = 1'b0;
    end else begin
      ctrl_nxt   = ctrl_r;
      phase_nxt  = phase_r;
      ticks_nxt  = ticks_r;
      period_nxt = period_r;
    end
    if (cmd.pack) begin
      if (cfg_low_r) begin
        if (cfg_rj_r) begin
          res1_nxt = conv[7:0];
          res0_nxt = {6'b000000, conv[9:8]};
        end else begin
          res1_nxt = {conv[1:0], 6'b000000};
          res0_nxt = conv[9:2];
        end
      end else begin
        res0_nxt = conv[7:0];
      end
      ctrl_nxt            = ctrl_r;
      ctrl_nxt[BIT_GO]    = 1'b0;
      ctrl_nxt[BIT_DONE]  = 1'b1;
      phase_nxt           = PH_IDLE;
      done_nxt            = 1'b1;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      phase_r  <= PH_IDLE;
      ticks_r  <= '0;
      period_r <= '0;
      res0_r   <= '0;
      res1_r   <= '0;
      done_r   <= 1'b0;
      vin_r    <= '0;
      vhi_r    <= '0;
      vlo_r    <= '0;
    end else begin
      ctrl_r   <= ctrl_nxt;
      phase_r  <= phase_nxt;
      ticks_r  <= ticks_nxt;
      period_r <= period_nxt;
      res0_r   <= res0_nxt;
      res1_r   <= res1_nxt;
      done_r   <= done_nxt;
      if (cmd.step && sample) begin
        vin_r <= item_vin;
        vhi_r <= item_vhi;
        vlo_r <= item_vlo;
      end
    end
  end

  // Numerator product and clamp flags from the sampled levels.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      den_r  <= vhi_r - vlo_r;
      prod_r <= PW'(scale) * PW'(vin_r - vlo_r);
      zero_r <= (vhi_r <= vlo_r) || (vin_r <= vlo_r);
      full_r <= vin_r >= vhi_r;
    end
  end

  // Rounded division (2*num + den) / (2*den).
  acc_div #(
    .DW(DW),
    .VW(VW),
    .QW(QW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (cmd.load),
    .dividend({prod_r, 1'b0} + DW'(den_r)),
    .divisor ({den_r, 1'b0}),
    .busy    (div_busy),
    .quotient(quotient)
  );

  assign status = '{finish: finish, div_busy: div_busy};

  // Result fields.
  assign control_value    = ctrl_r;
  assign result_high      = res0_r;
  assign result_low       = cfg_low_r ? res1_r : 8'd0;
  assign selected_channel = ctrl_r[5:3] & CHAN_MASK;
  assign phase            = phase_r;
  assign done_interrupt   = done_r;

endmodule

// ----- design/acc_ctrl.sv -----
module acc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output acc_pkg::acc_cmd_t    cmd,
  input  acc_pkg::acc_status_t status
);
  import acc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = state_r == ST_OUT;

  // Sequencing: a request either answers at once or runs the conversion end.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.step  = 1'b1;
          state_nxt = status.finish ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          cmd.pack  = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/adc_conversion_controller.sv -----
// Control block of a successive-approximation A/D converter.
// The input stream carries one request per beat: tuser 0 is an
// instruction-cycle tick, tuser 1 writes the control byte. Every request
// returns exactly one result beat holding the control byte, both result
// registers, the selected channel, the phase and a one-beat done flag.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata.
// The user must write them while no request is in flight; the block does
// not enforce this. A write or an ordinary tick answers in the cycle
// after acceptance. The tick that completes a conversion answers after
// the scale multiply, the divider load and the divider run, which
// retires one quotient bit per cycle. One request is handled at a time;
// the next one is taken in the cycle after its result beat leaves.
// While the receiver stalls, the result beat holds and in_tready stays low.
// Reset (rst_n low, synchronous) restores the register defaults, idles the
// converter and clears the result registers.
module adc_conversion_controller #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: write_value, channel_level, ref_high_level, ref_low_level
  input  logic [((8+3*LEVEL_BITS+7)/8)*8-1:0] in_tdata,
  // tuser: operation
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: control_value, result_high, result_low, selected_channel, phase,
  // done_interrupt
  output logic [acc_pkg::OUT_W-1:0]         out_tdata,
  input  logic                              cfg_we,
  input  logic [acc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [7:0]                        cfg_wdata
);
  import acc_pkg::*;

  localparam int L = LEVEL_BITS;

  acc_cmd_t    cmd;
  acc_status_t status;
  logic [7:0]  control_value, result_high, result_low;
  logic [2:0]  selected_channel;
  logic [1:0]  phase;
  logic        done_interrupt;

  acc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .cmd      (cmd),
    .status   (status)
  );

  acc_datapath #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .item_op         (in_tuser),
    .item_wval       (in_tdata[7:0]),
    .item_vin        (in_tdata[8+L-1:8]),
    .item_vhi        (in_tdata[8+2*L-1:8+L]),
    .item_vlo        (in_tdata[8+3*L-1:8+2*L]),
    .cmd             (cmd),
    .status          (status),
    .control_value   (control_value),
    .result_high     (result_high),
    .result_low      (result_low),
    .selected_channel(selected_channel),
    .phase           (phase),
    .done_interrupt  (done_interrupt)
  );

  assign out_tdata = {2'b00, done_interrupt, phase, selected_channel,
                      result_low, result_high, control_value};

endmodule

// ----- design/acc_checker.sv -----
module acc_checker #(
  parameter int LEVEL_BITS = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [((8+3*LEVEL_BITS+7)/8)*8-1:0] in_tdata,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [acc_pkg::OUT_W-1:0]         out_tdata
);

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // The phase field never carries the unused code.
  a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[28:27] != 2'd3)
    else $error("phase field holds an unused code");

  // A completed conversion leaves the block idle with GO clear and DONE set.
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[29]) |->
      (out_tdata[28:27] == 2'd0 && !out_tdata[2] && out_tdata[1]))
    else $error("done pulse with inconsistent control state");

  // A write that clears ADON answers next cycle, idle, echoing the byte.
  a_adon_off: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser && !in_tdata[0]) |=>
      (out_tvalid && out_tdata[28:27] == 2'd0 && !out_tdata[29] &&
       out_tdata[7:0] == $past(in_tdata[7:0])))
    else $error("ADON clear did not idle the converter");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result beat changed while stalled");

endmodule

bind adc_conversion_controller acc_checker #(.LEVEL_BITS(LEVEL_BITS)) u_acc_checker (.*);
